[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file of this block.
// Depends on nothing; included by name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge of clk while rstn is high.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same check, written against the block clock and reset names.
`define ASSERT_ACLK(label, prop, msg) \
    `ASSERT_CLK(label, aclk, aresetn, prop, msg)

`endif

[rtl/core/mmt_pkg.sv]
// Shared types, constants and the time base table of the multi-mode timer.
// Depends on nothing; imported by every module of the block.
package mmt_pkg;

    localparam int ACC_WIDTH_DEF = 64;
    localparam int HELD_W        = 64;
    localparam int PRESET_W      = 32;
    localparam int UNIT_W        = 32;
    localparam int DELTA_W       = 20;
    localparam int IN_TDATA_W    = 24;
    localparam int OUT_TDATA_W   = 40;
    localparam int APB_ADDR_W    = 4;
    localparam int APB_DATA_W    = 32;

    // Timer modes.
    localparam logic [1:0] MODE_ON_DELAY  = 2'd0;
    localparam logic [1:0] MODE_OFF_DELAY = 2'd1;
    localparam logic [1:0] MODE_PULSE     = 2'd2;
    localparam logic [1:0] MODE_FLASHER   = 2'd3;

    // Register indexes (paddr[3:2]).
    localparam logic [1:0] REG_MODE       = 2'd0;
    localparam logic [1:0] REG_BASE       = 2'd1;
    localparam logic [1:0] REG_PRESET_ON  = 2'd2;
    localparam logic [1:0] REG_PRESET_OFF = 2'd3;

    // Time base codes.
    localparam logic [2:0] BASE_US   = 3'd0;
    localparam logic [2:0] BASE_MS   = 3'd1;
    localparam logic [2:0] BASE_SEC  = 3'd2;
    localparam logic [2:0] BASE_MIN  = 3'd3;

    localparam logic [1:0] MODE_RESET = MODE_ON_DELAY;
    localparam logic [2:0] BASE_RESET = BASE_MS;

    typedef logic [UNIT_W-1:0] unit_t;

    // Microseconds per base unit; the unused codes count as hours.
    function automatic unit_t unit_of(input logic [2:0] base);
        unit_t u;
        case (base)
            BASE_US:  u = 32'd1;
            BASE_MS:  u = 32'd1000;
            BASE_SEC: u = 32'd1000000;
            BASE_MIN: u = 32'd60000000;
            default:  u = 32'd3600000000;
        endcase
        return u;
    endfunction

endpackage

[rtl/core/mmt_mul.sv]
// Registered 32 x 32 multiplier that scales a preset to microseconds.
// Depends on mmt_pkg; shared by both presets under the top-level sequencer.
module mmt_mul (
    input  logic                            aclk,
    input  logic [mmt_pkg::PRESET_W-1:0]    a,
    input  logic [mmt_pkg::UNIT_W-1:0]      b,
    output logic [mmt_pkg::HELD_W-1:0]      p
);
    import mmt_pkg::*;

    logic [HELD_W-1:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= HELD_W'(a) * HELD_W'(b);
    end

    assign p = p_reg;

endmodule

[rtl/core/mmt_div.sv]
// Restoring divider, one quotient bit per cycle, 32 steps per division.
// Depends on mmt_pkg. The caller keeps dividend below 2^32 times divisor.
module mmt_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [mmt_pkg::HELD_W-1:0]      dividend,
    input  logic [mmt_pkg::UNIT_W-1:0]      divisor,
    output logic                            done,
    output logic [mmt_pkg::UNIT_W-1:0]      quotient
);
    import mmt_pkg::*;

    logic [UNIT_W-1:0]   rem_reg, rem_next;
    logic [UNIT_W-1:0]   quo_reg, quo_next;
    logic [4:0]          cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [UNIT_W:0]     trial;
    logic [UNIT_W+1:0]   diff;
    logic                fits;

    always_comb begin
        trial     = {rem_reg, quo_reg[UNIT_W-1]};
        diff      = {1'b0, trial} - {2'b00, divisor};
        fits      = !diff[UNIT_W+1];
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = dividend[HELD_W-1:UNIT_W];
            quo_next  = dividend[UNIT_W-1:0];
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? diff[UNIT_W-1:0] : trial[UNIT_W-1:0];
            quo_next = {quo_reg[UNIT_W-2:0], fits};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/core/plc_multi_mode_timer.sv]
// PLC timer with on-delay, off-delay, pulse and flasher modes, one result per sample.
// Each sample runs through the two multiply states, sum, select and finish, and, when elapsed
// must be divided, through the 32-step serial divider by the time base; the block takes
// the next sample once the result is in the output register.
// Reset (aresetn low, synchronous) clears the timer state and loads register defaults.
// Depends on mmt_pkg, mmt_mul and mmt_div.
module plc_multi_mode_timer #(
    parameter int ACC_WIDTH = mmt_pkg::ACC_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // s_tdata: enable [0], clear [1], delta_us [21:2], zero pad [23:22]
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mmt_pkg::IN_TDATA_W-1:0]    s_tdata,
    // m_tdata: done_res [0], timing [1], elapsed [33:2], zero pad [39:34]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mmt_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mmt_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [mmt_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [mmt_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import mmt_pkg::*;

    localparam int SW = ACC_WIDTH + 1;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_MUL_ON  = 4'd1;
    localparam logic [3:0] ST_MUL_OFF = 4'd2;
    localparam logic [3:0] ST_SUM     = 4'd3;
    localparam logic [3:0] ST_SEL     = 4'd4;
    localparam logic [3:0] ST_FIN     = 4'd5;
    localparam logic [3:0] ST_DIV_GO  = 4'd6;
    localparam logic [3:0] ST_DIV     = 4'd7;
    localparam logic [3:0] ST_OUT     = 4'd8;

    // Configuration registers.
    logic [1:0]           mode_reg;
    logic [2:0]           base_reg;
    logic [PRESET_W-1:0]  preset_on_reg;
    logic [PRESET_W-1:0]  preset_off_reg;
    logic                 cfg_wr;

    // Sequencer and timer state.
    logic [3:0]           state_reg, state_next;
    logic [ACC_WIDTH-1:0] raw_reg, raw_next;
    logic [HELD_W-1:0]    held_reg, held_next;
    logic                 done_reg, done_next;
    logic                 en_prev_reg, en_prev_next;
    logic                 run_reg, run_next;

    // Captured sample and per-item intermediates.
    logic                 en_in_reg, clr_in_reg;
    logic [DELTA_W-1:0]   delta_reg;
    logic [HELD_W-1:0]    pt_reg, pt_next;
    logic [HELD_W:0]      ptsum_reg, ptsum_next;
    logic [ACC_WIDTH-1:0] sum_reg, sum_next;
    logic                 tt_reg, tt_next;
    logic [UNIT_W-1:0]    et_reg, et_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    unit_t                unit;
    logic [PRESET_W-1:0]  mul_a;
    logic [HELD_W-1:0]    mul_p;
    logic                 div_start, div_done;
    logic [UNIT_W-1:0]    div_quo;

    logic [SW-1:0]        raw_plus;
    logic [HELD_W-1:0]    sum_wide;
    logic                 rising, falling;
    logic                 ge_pt, gt_pt, held_nz, lt_sum, pt_nz;
    logic                 clamp, show, hf_nz, hf_le, hf_lt, need_div;

    assign unit      = unit_of(base_reg);
    assign mul_a     = (state_reg == ST_MUL_ON) ? preset_on_reg : preset_off_reg;
    assign div_start = (state_reg == ST_DIV_GO);

    mmt_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (unit),
        .p    (mul_p)
    );

    mmt_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (held_reg),
        .divisor  (unit),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_RESET;
            base_reg       <= BASE_RESET;
            preset_on_reg  <= '0;
            preset_off_reg <= '0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_MODE:       mode_reg       <= pwdata[1:0];
                REG_BASE:       base_reg       <= pwdata[2:0];
                REG_PRESET_ON:  preset_on_reg  <= pwdata;
                REG_PRESET_OFF: preset_off_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MODE:       prdata = APB_DATA_W'(mode_reg);
            REG_BASE:       prdata = APB_DATA_W'(base_reg);
            REG_PRESET_ON:  prdata = preset_on_reg;
            REG_PRESET_OFF: prdata = preset_off_reg;
            default:        prdata = '0;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        raw_plus = {1'b0, raw_reg} + SW'(delta_reg);
        sum_wide = HELD_W'(sum_reg);
        rising   = en_in_reg && !en_prev_reg;
        falling  = !en_in_reg && en_prev_reg;
        ge_pt    = held_reg >= pt_reg;
        gt_pt    = held_reg > pt_reg;
        held_nz  = held_reg != '0;
        lt_sum   = {1'b0, held_reg} < ptsum_reg;
        pt_nz    = pt_reg != '0;

        state_next    = state_reg;
        raw_next      = raw_reg;
        held_next     = held_reg;
        done_next     = done_reg;
        run_next      = run_reg;
        en_prev_next  = en_prev_reg;
        pt_next       = pt_reg;
        ptsum_next    = ptsum_reg;
        sum_next      = sum_reg;
        tt_next       = tt_reg;
        et_next       = et_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        clamp         = 1'b0;
        show          = 1'b1;
        hf_nz         = 1'b0;
        hf_le         = 1'b0;
        hf_lt         = 1'b0;
        need_div      = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_MUL_ON;
                end
            end
            ST_MUL_ON: begin
                state_next = ST_MUL_OFF;
            end
            ST_MUL_OFF: begin
                pt_next    = mul_p;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                // The accumulator saturates instead of wrapping.
                ptsum_next = {1'b0, pt_reg} + {1'b0, mul_p};
                sum_next   = raw_plus[ACC_WIDTH] ? '1 : raw_plus[ACC_WIDTH-1:0];
                state_next = ST_SEL;
            end
            ST_SEL: begin
                // First half of the step: edge handling and accumulation.
                case (mode_reg)
                    MODE_ON_DELAY: begin
                        if (en_in_reg) begin
                            if (rising) begin
                                held_next = '0;
                            end
                            if (!done_reg) begin
                                raw_next  = sum_reg;
                                held_next = sum_wide;
                            end
                        end else begin
                            raw_next  = '0;
                            done_next = 1'b0;
                        end
                    end
                    MODE_OFF_DELAY: begin
                        if (en_in_reg) begin
                            done_next = 1'b1;
                        end
                        if (rising) begin
                            held_next = '0;
                        end
                        run_next = rising ? 1'b0 : (falling ? 1'b1 : run_reg);
                        if (run_next) begin
                            raw_next  = sum_reg;
                            held_next = sum_wide;
                        end else begin
                            raw_next = '0;
                        end
                    end
                    MODE_PULSE: begin
                        if (rising) begin
                            // A fresh pulse starts from zero; this sample's time is dropped.
                            run_next  = 1'b1;
                            raw_next  = '0;
                            held_next = '0;
                            done_next = 1'b1;
                        end else if (falling && !done_reg) begin
                            run_next = 1'b0;
                            raw_next = '0;
                        end else if (falling && !run_reg) begin
                            raw_next = '0;
                        end else if (run_reg) begin
                            raw_next  = sum_reg;
                            held_next = sum_wide;
                            done_next = 1'b1;
                        end
                    end
                    default: begin
                        if (en_in_reg) begin
                            raw_next  = sum_reg;
                            held_next = sum_wide;
                        end else begin
                            raw_next  = '0;
                            held_next = '0;
                            done_next = 1'b0;
                        end
                    end
                endcase
                state_next = ST_FIN;
            end
            ST_FIN: begin
                // Second half: preset checks on the updated held time, then the clear input.
                case (mode_reg)
                    MODE_ON_DELAY: begin
                        if (en_in_reg) begin
                            if (ge_pt) begin
                                clamp     = 1'b1;
                                raw_next  = '0;
                                done_next = 1'b1;
                            end
                        end else begin
                            show = 1'b0;
                        end
                    end
                    MODE_OFF_DELAY: begin
                        if (!en_in_reg && ge_pt) begin
                            clamp     = 1'b1;
                            run_next  = 1'b0;
                            raw_next  = '0;
                            done_next = 1'b0;
                        end
                    end
                    MODE_PULSE: begin
                        if (ge_pt) begin
                            clamp     = 1'b1;
                            run_next  = 1'b0;
                            raw_next  = '0;
                            done_next = 1'b0;
                        end
                    end
                    default: begin
                        show = 1'b0;
                        if (held_nz && !ge_pt) begin
                            done_next = 1'b1;
                        end else if (gt_pt && lt_sum) begin
                            done_next = 1'b0;
                        end else if (!done_reg) begin
                            raw_next  = '0;
                            held_next = '0;
                        end
                    end
                endcase
                if (clamp) begin
                    held_next = pt_reg;
                end
                hf_nz    = clamp ? pt_nz : held_nz;
                hf_le    = clamp || !gt_pt;
                hf_lt    = !clamp && !ge_pt;
                tt_next  = show && hf_nz && hf_lt;
                need_div = show && hf_nz && hf_le;
                if (clr_in_reg) begin
                    raw_next  = '0;
                    held_next = '0;
                    run_next  = 1'b0;
                    done_next = 1'b0;
                    tt_next   = 1'b0;
                    need_div  = 1'b0;
                end
                en_prev_next = en_in_reg;
                et_next      = '0;
                state_next   = need_div ? ST_DIV_GO : ST_OUT;
            end
            ST_DIV_GO: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    et_next    = div_quo;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // Wait for the output register to be free before handing over.
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{(OUT_TDATA_W - UNIT_W - 2){1'b0}},
                                     et_reg, tt_reg, done_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            raw_reg      <= '0;
            held_reg     <= '0;
            done_reg     <= 1'b0;
            en_prev_reg  <= 1'b0;
            run_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            raw_reg      <= raw_next;
            held_reg     <= held_next;
            done_reg     <= done_next;
            en_prev_reg  <= en_prev_next;
            run_reg      <= run_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        if (s_tvalid && s_tready) begin
            en_in_reg  <= s_tdata[0];
            clr_in_reg <= s_tdata[1];
            delta_reg  <= s_tdata[DELTA_W+1:2];
        end
        pt_reg      <= pt_next;
        ptsum_reg   <= ptsum_next;
        sum_reg     <= sum_next;
        tt_reg      <= tt_next;
        et_reg      <= et_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

[rtl/core/mmt_checker.sv]
// Port-level checks of the multi-mode timer, bound to the top level.
// Depends on mmt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mmt_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [mmt_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import mmt_pkg::*;

    // An accepted sample keeps the block busy in the following cycle.
    `ASSERT_ACLK(busy_after_accept, s_tvalid && s_tready |=> !s_tready, "accepted while busy")

    // A new result only appears as the block finishes working on a sample.
    `ASSERT_ACLK(result_from_work, $rose(m_tvalid) |-> !$past(s_tready), "result without work")

    // A stalled result transfer keeps its data.
    `ASSERT_ACLK(out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result dropped")

endmodule

bind plc_multi_mode_timer mmt_checker u_mmt_checker (.*);
